/* rtl/mkey_pkg.sv */
`default_nettype none

package mkey_pkg;

  // ASCII codes used by the classifier
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Segment lengths in time units
  localparam logic [2:0] DUR_DOT   = 3'd1;
  localparam logic [2:0] DUR_DASH  = 3'd3;
  localparam logic [2:0] DUR_GAP   = 3'd1;
  localparam logic [2:0] DUR_CHAR  = 3'd3;
  localparam logic [2:0] DUR_WORD  = 3'd4;

  // Command queue between classifier and sequencer
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Element pattern: count and bits, first element in bit 0, 1 = dash
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] bits;
  } pat_t;

  // One classified character
  typedef struct packed {
    logic word_gap;
    pat_t pat;
  } cmd_t;

  localparam logic [7:0] ALPHA_TAB [26] = '{
    8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80, 8'h40, 8'h8E,
    8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86, 8'h8B, 8'h62, 8'h60, 8'h21,
    8'h64, 8'h88, 8'h66, 8'h89, 8'h8D, 8'h83
  };

  localparam logic [7:0] DIGIT_TAB [10] = '{
    8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0, 8'hA1, 8'hA3, 8'hA7, 8'hAF
  };

endpackage

`default_nettype wire

/* rtl/mkey_if.sv */
`default_nettype none

// Character channel
interface mkey_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// Keying segment channel
interface mkey_seg_if;
  logic       valid;
  logic       ready;
  logic       key_on;
  logic [2:0] duration_units;
  logic       last_segment;

  modport source (output valid, output key_on, output duration_units,
                  output last_segment, input ready);
  modport sink   (input valid, input key_on, input duration_units,
                  input last_segment, output ready);
endinterface

`default_nettype wire

/* rtl/mkey_front.sv */
`default_nettype none

module mkey_front (
  input  wire logic          [7:0] char_code,
  output      mkey_pkg::cmd_t      cmd,
  output      logic                cmd_keep
);
  import mkey_pkg::*;

  logic       is_lower;
  logic       is_upper;
  logic       is_digit;
  logic       is_gap;
  logic [4:0] lower_off;
  logic [4:0] upper_off;
  logic [3:0] digit_off;
  logic [7:0] entry;

  // Range checks
  assign is_lower = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_Z);
  assign is_upper = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_Z);
  assign is_digit = (char_code >= CHAR_DIGIT_0) && (char_code <= CHAR_DIGIT_9);
  assign is_gap   = (char_code == CHAR_SPACE) || (char_code == CHAR_NEWLINE);

  assign lower_off = 5'(char_code - CHAR_LOWER_A);
  assign upper_off = 5'(char_code - CHAR_UPPER_A);
  assign digit_off = 4'(char_code - CHAR_DIGIT_0);

  // Pattern lookup
  always_comb begin
    priority if (is_lower) begin
      entry = ALPHA_TAB[lower_off];
    end else if (is_upper) begin
      entry = ALPHA_TAB[upper_off];
    end else if (is_digit) begin
      entry = DIGIT_TAB[digit_off];
    end else begin
      entry = '0;
    end
  end

  assign cmd.word_gap = is_gap;
  assign cmd.pat      = pat_t'(entry);
  // unsupported codes are accepted and dropped
  assign cmd_keep     = is_lower || is_upper || is_digit || is_gap;

endmodule

`default_nettype wire

/* rtl/mkey_queue.sv */
`default_nettype none

module mkey_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mkey_pkg::cmd_t push_cmd,
  output      logic           full,
  input  wire logic           pop,
  output      mkey_pkg::cmd_t pop_cmd,
  output      logic           avail
);
  import mkey_pkg::*;

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign full    = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign avail   = (count != '0);
  assign pop_cmd = mem[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/mkey_back.sv */
`default_nettype none

module mkey_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_avail,
  input  wire mkey_pkg::cmd_t cmd_in,
  output      logic           cmd_pop,
  mkey_seg_if.source          seg_out
);
  import mkey_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_SPACE,
    ST_CLOSE,
    ST_WORD
  } state_t;

  state_t     state;
  pat_t       pat;
  logic [2:0] idx;
  logic       can_emit;
  logic       emit;
  logic       finishing;
  logic       seg_key;
  logic [2:0] seg_dur;
  logic       seg_last;

  assign can_emit  = !seg_out.valid || seg_out.ready;
  assign emit      = can_emit && (state != ST_IDLE);
  assign finishing = emit && (state == ST_CLOSE);
  assign cmd_pop   = cmd_avail && ((state == ST_IDLE) || finishing);

  // Segment for the current step
  always_comb begin
    seg_key  = 1'b0;
    seg_dur  = DUR_CHAR;
    seg_last = 1'b0;
    unique case (state)
      ST_MARK: begin
        seg_key = 1'b1;
        seg_dur = pat.bits[idx] ? DUR_DASH : DUR_DOT;
      end
      ST_SPACE: seg_dur = DUR_GAP;
      ST_WORD:  seg_dur = DUR_WORD;
      ST_CLOSE: seg_last = 1'b1;
      default: begin
        seg_dur = DUR_CHAR;
      end
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      idx           <= '0;
      seg_out.valid <= 1'b0;
    end else begin
      if (emit) begin
        seg_out.valid          <= 1'b1;
        seg_out.key_on         <= seg_key;
        seg_out.duration_units <= seg_dur;
        seg_out.last_segment   <= seg_last;
      end else if (seg_out.ready) begin
        seg_out.valid <= 1'b0;
      end

      if (cmd_pop) begin
        pat   <= cmd_in.pat;
        idx   <= '0;
        state <= cmd_in.word_gap ? ST_WORD : ST_MARK;
      end else if (emit) begin
        unique case (state)
          ST_MARK:  state <= ST_SPACE;
          ST_SPACE: begin
            if (idx + 3'd1 == pat.len) begin
              state <= ST_CLOSE;
            end else begin
              idx   <= idx + 3'd1;
              state <= ST_MARK;
            end
          end
          ST_WORD:  state <= ST_CLOSE;
          default:  state <= ST_IDLE;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/morse_character_keyer.sv */
`default_nettype none

// Channel   Dir  Payload                                      Handshake
// char_in   in   char_code[7:0]                               valid/ready
// seg_out   out  key_on, duration_units[2:0], last_segment    valid/ready
//
// A character gives 2 to 11 segments on the output: the back-end sequencer
// emits one keying segment per cycle unless the output stalls (dot or dash,
// gap, etc., closing gap). Unsupported codes are taken and give nothing.
// A two-entry command queue lets characters enter while the sequencer works.
// Reset (rst, synchronous) empties the queue, idles the sequencer and
// drops the output register. Output stalls hold the segment in place.

module morse_character_keyer (
  input  wire logic  clk,
  input  wire logic  rst,
  mkey_char_if.sink  char_in,
  mkey_seg_if.source seg_out
);
  import mkey_pkg::*;

  cmd_t front_cmd;
  logic front_keep;
  cmd_t queue_cmd;
  logic queue_full;
  logic queue_avail;
  logic queue_pop;
  logic queue_push;

  assign char_in.ready = !queue_full;
  assign queue_push    = char_in.valid && char_in.ready && front_keep;

  mkey_front u_front (
    .char_code (char_in.char_code),
    .cmd       (front_cmd),
    .cmd_keep  (front_keep)
  );

  mkey_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (queue_push),
    .push_cmd (front_cmd),
    .full     (queue_full),
    .pop      (queue_pop),
    .pop_cmd  (queue_cmd),
    .avail    (queue_avail)
  );

  mkey_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (queue_avail),
    .cmd_in    (queue_cmd),
    .cmd_pop   (queue_pop),
    .seg_out   (seg_out)
  );

endmodule

`default_nettype wire

/* rtl/mkey_checker.sv */
`default_nettype none

module mkey_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       key_on,
  input wire logic [2:0] duration_units,
  input wire logic       last_segment
);

  // A stalled segment holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_on)
      && $stable(duration_units) && $stable(last_segment))
    else $error("segment changed while stalled");

  // Keyed segments are dots or dashes and never close a character
  a_key_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_on |-> !last_segment
      && (duration_units == 3'd1 || duration_units == 3'd3))
    else $error("bad keyed segment");

  // The closing segment is a silent character gap
  a_close_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_segment |-> !key_on && duration_units == 3'd3)
    else $error("bad closing segment");

  // A keyed segment is always followed by a one-unit silent gap
  a_mark_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && key_on |=> out_valid && !key_on
      && duration_units == 3'd1)
    else $error("mark not followed by element gap");

endmodule

bind morse_character_keyer mkey_checker u_mkey_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (seg_out.valid),
  .out_ready      (seg_out.ready),
  .key_on         (seg_out.key_on),
  .duration_units (seg_out.duration_units),
  .last_segment   (seg_out.last_segment)
);

`default_nettype wire
